>>> rtl/core/bnavg_pkg.sv
// ----------------------------------------------------------------------------
// bnavg_pkg
// Shared widths, register indexes and the front-to-back queue entry type
// for the block binning average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bnavg_pkg;

  localparam int unsigned MaxWidth  = 4096;
  localparam int unsigned MaxBin    = 16;
  localparam int unsigned PixelBits = 16;
  localparam int unsigned HeightCap = 4096;

  localparam int unsigned ColW    = $clog2(MaxWidth);      // column / position bits
  localparam int unsigned SizeW   = ColW + 1;              // frame size register bits
  localparam int unsigned PosW    = SizeW + 1;             // headroom for bound compares
  localparam int unsigned InBinW  = $clog2(MaxBin);        // offset inside a block
  localparam int unsigned BinW    = InBinW + 1;            // bin factor register bits
  localparam int unsigned SqW     = 2 * InBinW + 1;        // bin factor squared
  localparam int unsigned RowSumW = PixelBits + InBinW;    // one block row of pixels
  localparam int unsigned SumW    = 24;
  localparam int unsigned FracBits = 8;
  localparam int unsigned QuoW    = SumW + FracBits;
  localparam int unsigned CntW    = $clog2(QuoW);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 13;

  localparam logic [CfgIdxW-1:0] CfgBinFactor   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  localparam logic [BinW-1:0]  BinReset  = 5'd4;
  localparam logic [SizeW-1:0] SizeReset = 13'd2048;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  // One block row segment handed from the front to the back.
  typedef struct packed {
    logic [ColW-1:0]    addr;
    logic [RowSumW-1:0] row_sum;
    logic               first_row;
    logic               emit;
    logic               frame_end;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/image_block_binning_average_unit.sv
// ----------------------------------------------------------------------------
// image_block_binning_average_unit
// Box-average binning: sums bin_factor x bin_factor pixel blocks in a
// per-column accumulator store and emits each block mean with 8 fraction
// bits.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        pixel_i
//  result    empty / pop        bin_mean_o, frame_end_o
//  config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
//  The front takes one pixel a cycle while its four-entry queue has room.
//  The back spends its idle (queue pop, accumulator read) and add (accumulator
//  write) states on each block row segment (one entry every bin_factor pixels),
//  plus the 32-step divider and the output load on each finished block, and
//  takes the next entry only after it is back in its idle state.
//  Reset clears counters, queue and output; the accumulators are not cleared.
//  A waiting result holds the back end only in its output load step.
// ----------------------------------------------------------------------------
`default_nettype none

module image_block_binning_average_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [bnavg_pkg::PixelBits-1:0] pixel_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [bnavg_pkg::SumW-1:0]           bin_mean_o,
  output logic                                 frame_end_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [bnavg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bnavg_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  logic                         accept;
  logic                         entry_valid;
  bnavg_pkg::entry_t            entry;
  bnavg_pkg::entry_t            head;
  logic                         fifo_full, fifo_empty, fifo_pop;
  logic [bnavg_pkg::SqW-1:0]    bin_sq;

  // stall the input whenever the queue is full, even for pixels that
  // would not produce an entry
  assign full   = fifo_full;
  assign accept = push && !fifo_full;

  bnavg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .pixel_i      (pixel_i),
    .entry_valid_o(entry_valid),
    .entry_o      (entry),
    .bin_sq_o     (bin_sq)
  );

  bnavg_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (entry_valid),
    .data_i (entry),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .data_o (head),
    .empty_o(fifo_empty)
  );

  bnavg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_empty_i(fifo_empty),
    .fifo_data_i (head),
    .fifo_pop_o  (fifo_pop),
    .bin_sq_i    (bin_sq),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .bin_mean_o  (bin_mean_o),
    .frame_end_o (frame_end_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/bnavg_front.sv
// ----------------------------------------------------------------------------
// bnavg_front
// Holds the configuration and the frame position counters, sums each block
// row segment and classifies it into a queue entry for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bnavg_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bnavg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [bnavg_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  wire logic                            accept_i,
  input  wire logic [bnavg_pkg::PixelBits-1:0] pixel_i,
  output logic                                 entry_valid_o,
  output bnavg_pkg::entry_t                    entry_o,
  output logic [bnavg_pkg::SqW-1:0]            bin_sq_o
);

  logic [bnavg_pkg::BinW-1:0]  bin_factor_q;
  logic [bnavg_pkg::SizeW-1:0] frame_width_q, frame_height_q;

  logic [bnavg_pkg::BinW-1:0]   eff_b;
  logic [bnavg_pkg::SizeW-1:0]  eff_w, eff_h;
  logic [bnavg_pkg::InBinW-1:0] b_m1;
  logic [bnavg_pkg::BinW:0]     two_b;
  logic [bnavg_pkg::BinW+1:0]   three_b;

  logic [bnavg_pkg::ColW-1:0]   x_pos_q, x_pos_d, y_pos_q, y_pos_d;
  logic [bnavg_pkg::InBinW-1:0] x_in_q, x_in_d, y_in_q, y_in_d;
  logic [bnavg_pkg::ColW-1:0]   bin_col_q, bin_col_d;
  logic [bnavg_pkg::ColW-1:0]   x_start_q, x_start_d, y_start_q, y_start_d;
  logic [bnavg_pkg::RowSumW-1:0] hsum_q, hsum_sum;

  logic x_in_last, y_in_last, x_wrap, y_wrap;
  logic kept_x, kept_y, last_x_blk, last_y_blk;

  always_comb begin
    if (bin_factor_q == '0) begin
      eff_b = bnavg_pkg::BinW'(1);
    end else if (bin_factor_q > bnavg_pkg::BinW'(bnavg_pkg::MaxBin)) begin
      eff_b = bnavg_pkg::BinW'(bnavg_pkg::MaxBin);
    end else begin
      eff_b = bin_factor_q;
    end
    if (frame_width_q == '0) begin
      eff_w = bnavg_pkg::SizeW'(1);
    end else if (frame_width_q > bnavg_pkg::SizeW'(bnavg_pkg::MaxWidth)) begin
      eff_w = bnavg_pkg::SizeW'(bnavg_pkg::MaxWidth);
    end else begin
      eff_w = frame_width_q;
    end
    if (frame_height_q == '0) begin
      eff_h = bnavg_pkg::SizeW'(1);
    end else if (frame_height_q > bnavg_pkg::SizeW'(bnavg_pkg::HeightCap)) begin
      eff_h = bnavg_pkg::SizeW'(bnavg_pkg::HeightCap);
    end else begin
      eff_h = frame_height_q;
    end
  end

  assign b_m1    = bnavg_pkg::InBinW'(eff_b - bnavg_pkg::BinW'(1));
  assign two_b   = {eff_b, 1'b0};
  assign three_b = {1'b0, two_b} + (bnavg_pkg::BinW + 2)'(eff_b);
  assign bin_sq_o = bnavg_pkg::SqW'(eff_b) * bnavg_pkg::SqW'(eff_b);

  // A block is kept when the next block on its axis still fits in the frame;
  // it is the last kept one when the block after that does not.
  assign kept_x     = (bnavg_pkg::PosW'(x_start_q) + bnavg_pkg::PosW'(two_b))
                      <= bnavg_pkg::PosW'(eff_w);
  assign kept_y     = (bnavg_pkg::PosW'(y_start_q) + bnavg_pkg::PosW'(two_b))
                      <= bnavg_pkg::PosW'(eff_h);
  assign last_x_blk = (bnavg_pkg::PosW'(x_start_q) + bnavg_pkg::PosW'(three_b))
                      > bnavg_pkg::PosW'(eff_w);
  assign last_y_blk = (bnavg_pkg::PosW'(y_start_q) + bnavg_pkg::PosW'(three_b))
                      > bnavg_pkg::PosW'(eff_h);

  assign x_in_last = (x_in_q == b_m1);
  assign y_in_last = (y_in_q == b_m1);
  assign x_wrap    = (bnavg_pkg::SizeW'(x_pos_q) + bnavg_pkg::SizeW'(1)) >= eff_w;
  assign y_wrap    = (bnavg_pkg::SizeW'(y_pos_q) + bnavg_pkg::SizeW'(1)) >= eff_h;

  assign hsum_sum = ((x_in_q == '0) ? '0 : hsum_q) + bnavg_pkg::RowSumW'(pixel_i);

  assign entry_valid_o     = accept_i && x_in_last && kept_x && kept_y;
  assign entry_o.addr      = bin_col_q;
  assign entry_o.row_sum   = hsum_sum;
  assign entry_o.first_row = (y_in_q == '0);
  assign entry_o.emit      = y_in_last;
  assign entry_o.frame_end = last_x_blk && last_y_blk;

  always_comb begin
    x_pos_d   = x_pos_q;
    x_in_d    = x_in_q;
    bin_col_d = bin_col_q;
    x_start_d = x_start_q;
    y_pos_d   = y_pos_q;
    y_in_d    = y_in_q;
    y_start_d = y_start_q;
    if (cfg_we_i) begin
      // any register write restarts the frame
      x_pos_d   = '0;
      x_in_d    = '0;
      bin_col_d = '0;
      x_start_d = '0;
      y_pos_d   = '0;
      y_in_d    = '0;
      y_start_d = '0;
    end else if (accept_i) begin
      if (x_wrap) begin
        x_pos_d   = '0;
        x_in_d    = '0;
        bin_col_d = '0;
        x_start_d = '0;
        if (y_wrap) begin
          y_pos_d   = '0;
          y_in_d    = '0;
          y_start_d = '0;
        end else begin
          y_pos_d = y_pos_q + bnavg_pkg::ColW'(1);
          if (y_in_last) begin
            y_in_d    = '0;
            y_start_d = bnavg_pkg::ColW'(bnavg_pkg::SizeW'(y_start_q)
                                         + bnavg_pkg::SizeW'(eff_b));
          end else begin
            y_in_d = y_in_q + bnavg_pkg::InBinW'(1);
          end
        end
      end else begin
        x_pos_d = x_pos_q + bnavg_pkg::ColW'(1);
        if (x_in_last) begin
          x_in_d    = '0;
          bin_col_d = bin_col_q + bnavg_pkg::ColW'(1);
          x_start_d = bnavg_pkg::ColW'(bnavg_pkg::SizeW'(x_start_q)
                                       + bnavg_pkg::SizeW'(eff_b));
        end else begin
          x_in_d = x_in_q + bnavg_pkg::InBinW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_factor_q   <= bnavg_pkg::BinReset;
      frame_width_q  <= bnavg_pkg::SizeReset;
      frame_height_q <= bnavg_pkg::SizeReset;
      x_pos_q        <= '0;
      x_in_q         <= '0;
      bin_col_q      <= '0;
      x_start_q      <= '0;
      y_pos_q        <= '0;
      y_in_q         <= '0;
      y_start_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bnavg_pkg::CfgBinFactor:   bin_factor_q   <= cfg_wdata_i[bnavg_pkg::BinW-1:0];
          bnavg_pkg::CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
          bnavg_pkg::CfgFrameHeight: frame_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      x_pos_q   <= x_pos_d;
      x_in_q    <= x_in_d;
      bin_col_q <= bin_col_d;
      x_start_q <= x_start_d;
      y_pos_q   <= y_pos_d;
      y_in_q    <= y_in_d;
      y_start_q <= y_start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hsum_q <= hsum_sum;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bnavg_fifo.sv
// ----------------------------------------------------------------------------
// bnavg_fifo
// Short queue of block row segments between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bnavg_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bnavg_pkg::entry_t data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output bnavg_pkg::entry_t      data_o,
  output logic                   empty_o
);

  bnavg_pkg::entry_t store_q [bnavg_pkg::FifoDepth];

  logic [bnavg_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [bnavg_pkg::FifoAw:0]   count_q;
  logic                         do_push, do_pop;

  assign full_o  = (count_q == (bnavg_pkg::FifoAw + 1)'(bnavg_pkg::FifoDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + bnavg_pkg::FifoAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + bnavg_pkg::FifoAw'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (bnavg_pkg::FifoAw + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (bnavg_pkg::FifoAw + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bnavg_back.sv
// ----------------------------------------------------------------------------
// bnavg_back
// Writes a block's first row segment into its column accumulator, adds each
// later one to it, divides finished block sums by the block area and holds
// the result for the consumer.
`default_nettype none

module bnavg_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fifo_empty_i,
  input  wire bnavg_pkg::entry_t             fifo_data_i,
  output logic                               fifo_pop_o,
  input  wire logic [bnavg_pkg::SqW-1:0]     bin_sq_i,
  input  wire logic                          out_pop_i,
  output logic                               out_empty_o,
  output logic [bnavg_pkg::SumW-1:0]         bin_mean_o,
  output logic                               frame_end_o
);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SAdd  = 2'd1;
  localparam logic [1:0] SDiv  = 2'd2;
  localparam logic [1:0] SOut  = 2'd3;

  logic [bnavg_pkg::SumW-1:0] mem [bnavg_pkg::MaxWidth];
  logic [bnavg_pkg::SumW-1:0] rd_data_q;

  logic [1:0]                  state_q, state_d;
  bnavg_pkg::entry_t           cur_q;
  logic [bnavg_pkg::SumW-1:0]  sum;
  logic [bnavg_pkg::QuoW-1:0]  quo_q;
  logic [bnavg_pkg::SqW-1:0]   rem_q;
  logic [bnavg_pkg::CntW-1:0]  cnt_q;
  logic [bnavg_pkg::SqW+1:0]   trial;
  logic                        trial_ge;
  logic                        out_valid_q;
  logic [bnavg_pkg::SumW-1:0]  out_mean_q;
  logic                        out_fend_q;
  logic                        out_free, out_load, mem_we;

  assign fifo_pop_o = (state_q == SIdle) && !fifo_empty_i;
  assign mem_we     = (state_q == SAdd);
  assign sum        = cur_q.first_row ? bnavg_pkg::SumW'(cur_q.row_sum)
                                      : rd_data_q + bnavg_pkg::SumW'(cur_q.row_sum);

  // restoring division, one quotient bit a cycle
  assign trial    = {1'b0, rem_q, quo_q[bnavg_pkg::QuoW-1]}
                    - (bnavg_pkg::SqW + 2)'(bin_sq_i);
  assign trial_ge = !trial[bnavg_pkg::SqW+1];

  assign out_free    = !out_valid_q || out_pop_i;
  assign out_load    = (state_q == SOut) && out_free;
  assign out_empty_o = !out_valid_q;
  assign bin_mean_o  = out_mean_q;
  assign frame_end_o = out_fend_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (!fifo_empty_i) begin
        state_d = SAdd;
      end
      SAdd: state_d = cur_q.emit ? SDiv : SIdle;
      SDiv: if (cnt_q == bnavg_pkg::CntW'(bnavg_pkg::QuoW - 1)) begin
        state_d = SOut;
      end
      SOut: if (out_free) begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SDiv) begin
        cnt_q <= cnt_q + bnavg_pkg::CntW'(1);
      end else begin
        cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cur_q.addr] <= sum;
    end
    if (fifo_pop_o) begin
      rd_data_q <= mem[fifo_data_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      cur_q <= fifo_data_i;
    end
    if (state_q == SAdd) begin
      quo_q <= {sum, bnavg_pkg::FracBits'(0)};
      rem_q <= '0;
    end else if (state_q == SDiv) begin
      quo_q <= {quo_q[bnavg_pkg::QuoW-2:0], trial_ge};
      rem_q <= trial_ge ? trial[bnavg_pkg::SqW-1:0]
                        : {rem_q[bnavg_pkg::SqW-2:0], quo_q[bnavg_pkg::QuoW-1]};
    end
    if (out_load) begin
      out_mean_q <= quo_q[bnavg_pkg::SumW-1:0];
      out_fend_q <= cur_q.frame_end;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bnavg_checker.sv
// ----------------------------------------------------------------------------
// bnavg_checker
// Port-level checks on the binning unit's result queue and reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module bnavg_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            full,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [bnavg_pkg::SumW-1:0]      bin_mean_i,
  input wire logic                            frame_end_i
);

  // a waiting result is never dropped
  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result vanished without pop");

  // a waiting result does not change
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(bin_mean_i) && $stable(frame_end_i))
    else $error("waiting result changed");

  // two results can be taken back to back, but the divider cannot have a third one ready behind them
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty) ##1 (pop && !empty) |=> empty)
    else $error("third result too soon after two pops");

  // leaving reset: no result and the queue open
  a_reset_state: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("bad state after reset");

endmodule

bind image_block_binning_average_unit bnavg_checker u_bnavg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .bin_mean_i (bin_mean_o),
  .frame_end_i(frame_end_o)
);

`default_nettype wire
